// ----- rtl/core/tmca_pkg.sv -----
// Shared types, constants and helpers of the tiered memory capacity allocator.
// No dependencies; every other file of the block imports this package.
package tmca_pkg;

   // Tier count and byte-count width
   localparam int NUM_TIERS = 5;
   localparam int SIZE_BITS = 35;
   localparam int TIER_BITS = 3;
   localparam int ADDR_BITS = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
   // Number of writable capacity registers
   localparam int CAP_REGS  = 5;

   // Divide-by-ten unit: shift-and-add estimate, then one remainder fix-up
   localparam int DIV_BY    = 10;
   localparam int DIV_STEPS = 6;
   localparam int REM_BITS  = $clog2(2 * DIV_BY);
   localparam int STEP_BITS = $clog2(DIV_STEPS + 1);

   // Divider step codes, counted down from DIV_STEPS
   localparam logic [STEP_BITS-1:0] DIV_FOLD4  = STEP_BITS'(6);
   localparam logic [STEP_BITS-1:0] DIV_FOLD8  = STEP_BITS'(5);
   localparam logic [STEP_BITS-1:0] DIV_FOLD16 = STEP_BITS'(4);
   localparam logic [STEP_BITS-1:0] DIV_FOLD32 = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] DIV_SCALE  = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] DIV_FIX    = STEP_BITS'(1);

   // Preferred tier product width: 9-bit priority distance times tier span
   localparam int PRIO_BITS = 9;
   localparam int PREF_W    = PRIO_BITS + TIER_BITS;
   localparam int PRIO_ONE  = 256;

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [TIER_BITS-1:0] tier_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   // Capacity after reset, per tier
   localparam logic [63:0] CAP_RESET_TAB [8] = '{
      64'h0000_0000_0400_0000,
      64'h0000_0000_1000_0000,
      64'h0000_0000_4000_0000,
      64'h0000_0001_0000_0000,
      64'h0000_0004_0000_0000,
      64'h0, 64'h0, 64'h0
   };

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_REORG  = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_BAD_TIER = 2'd2
   } stat_type;

   // Write port of the usage memory
   typedef struct packed {
      logic     en;
      addr_type addr;
      size_type data;
   } mem_wr_type;

   // Preferred tier: floor((256 - min(p,256)) * (NUM_TIERS-1) / 256)
   function automatic addr_type pref_tier(input logic [PRIO_BITS-1:0] prio);
      logic [PRIO_BITS-1:0] prio_gap;
      logic [PREF_W-1:0]    prod;
      if (prio >= PRIO_BITS'(PRIO_ONE)) begin
         prio_gap = '0;
      end else begin
         prio_gap = PRIO_BITS'(PRIO_ONE) - prio;
      end
      prod = PREF_W'(prio_gap) * PREF_W'(NUM_TIERS - 1);
      return prod[8 +: ADDR_BITS];
   endfunction

endpackage

// ----- rtl/core/tmca_req_if.sv -----
// Request channel of the tiered memory capacity allocator.
// Depends on tmca_pkg for field widths.
interface tmca_req_if;
   import tmca_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   size_type             req_size;
   logic [PRIO_BITS-1:0] priority_q8;
   tier_type             tier_index;

   modport source (output valid, kind, req_size, priority_q8, tier_index, input ready);
   modport sink   (input valid, kind, req_size, priority_q8, tier_index, output ready);
endinterface

// ----- rtl/core/tmca_rsp_if.sv -----
// Response channel of the tiered memory capacity allocator.
// Depends on tmca_pkg for field widths.
interface tmca_rsp_if;
   import tmca_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] status;
   tier_type   granted_tier;
   size_type   tier_used;

   modport source (output valid, status, granted_tier, tier_used, input ready);
   modport sink   (input valid, status, granted_tier, tier_used, output ready);
endinterface

// ----- rtl/core/tmca_used_ram.sv -----
// Per-tier used-byte memory: one write port, one registered read port.
// Valid bits make unwritten entries read as zero after reset. Uses tmca_pkg.
module tmca_used_ram (
   input  logic                 clock,
   input  logic                 reset,
   input  tmca_pkg::mem_wr_type wr,
   input  tmca_pkg::addr_type   rd_addr,
   output tmca_pkg::size_type   rd_data
);
   import tmca_pkg::*;

   size_type               mem_ff [NUM_TIERS];
   logic [NUM_TIERS-1:0]   valid_ff;
   size_type               rd_data_ff;

   // Storage array
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Registered read with write-through on an address match
   always_ff @(posedge clock) begin
      if (wr.en && wr.addr == rd_addr) begin
         rd_data_ff <= wr.data;
      end else if (valid_ff[rd_addr]) begin
         rd_data_ff <= mem_ff[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tmca_div10.sv -----
// Divide-by-ten unit, one lane per tier capacity: shift-and-add reciprocal
// estimate with a final remainder fix-up. Result is ready once busy falls after
// the fix-up step. Uses tmca_pkg.
module tmca_div10 (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tmca_pkg::size_type dividend [tmca_pkg::NUM_TIERS],
   output logic               busy,
   output tmca_pkg::size_type quotient [tmca_pkg::NUM_TIERS]
);
   import tmca_pkg::*;

   logic [STEP_BITS-1:0] step_ff;
   size_type             num_ff  [NUM_TIERS];
   size_type             quot_ff [NUM_TIERS];
   logic [REM_BITS-1:0]  rem_ff  [NUM_TIERS];
   size_type             quot_in [NUM_TIERS];
   logic [REM_BITS-1:0]  rem_in  [NUM_TIERS];

   assign busy = (step_ff != '0);

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (start) begin
         step_ff <= STEP_BITS'(DIV_STEPS);
      end else if (busy) begin
         step_ff <= step_ff - 1'b1;
      end
   end

   // Per lane: q ~ 0.8n by folding, q/8 is floor(n/10) or one below,
   // the remainder (0..19) decides the final +1
   always_comb begin
      for (int l = 0; l < NUM_TIERS; l++) begin
         quot_in[l] = quot_ff[l];
         rem_in[l]  = rem_ff[l];
         unique case (step_ff)
            DIV_FOLD4:  quot_in[l] = quot_ff[l] + (quot_ff[l] >> 4);
            DIV_FOLD8:  quot_in[l] = quot_ff[l] + (quot_ff[l] >> 8);
            DIV_FOLD16: quot_in[l] = quot_ff[l] + (quot_ff[l] >> 16);
            DIV_FOLD32: quot_in[l] = quot_ff[l] + (quot_ff[l] >> 32);
            DIV_SCALE: begin
               quot_in[l] = quot_ff[l] >> 3;
               rem_in[l]  = REM_BITS'(num_ff[l] - ((quot_ff[l] >> 3) << 3)
                                                - ((quot_ff[l] >> 3) << 1));
            end
            DIV_FIX: begin
               quot_in[l] = quot_ff[l] + size_type'(rem_ff[l] >= REM_BITS'(DIV_BY));
            end
            default: begin
               quot_in[l] = quot_ff[l];
               rem_in[l]  = rem_ff[l];
            end
         endcase
      end
   end

   // Lane registers
   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_TIERS; l++) begin
         if (start) begin
            num_ff[l]  <= dividend[l];
            rem_ff[l]  <= '0;
            quot_ff[l] <= (dividend[l] >> 1) + (dividend[l] >> 2);
         end else if (busy) begin
            rem_ff[l]  <= rem_in[l];
            quot_ff[l] <= quot_in[l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_TIERS; l++) begin
         quotient[l] = quot_ff[l];
      end
   end

endmodule

// ----- rtl/core/tiered_memory_capacity_allocator.sv -----
// Tiered memory capacity allocator, top level.
// Holds per-tier capacity registers and the sequencer; instantiates tmca_used_ram
// and tmca_div10. Uses tmca_pkg, tmca_req_if and tmca_rsp_if.
//
// Usage:
//   The req channel carries one request (allocate, deallocate, reorganize or
//   status read); every request yields exactly one response on the rsp channel,
//   in order. Capacities are written through csr_we/csr_index/csr_data while
//   the block is idle; index k sets tier k, other indexes are ignored.
//   The block serves one request at a time. req.ready is high while the
//   sequencer is idle; a response waiting in the output register does not
//   keep the next request from being taken.
//   Status read and deallocate read the usage entry of their tier once; a
//   request for an invalid tier is answered without a read. Allocate reads
//   the usage memory once per scanned tier, from the preferred tier upward,
//   then downward from just below it. Reorganize divides the capacities by
//   ten, then walks the adjacent tier pairs in order through the usage
//   memory. With a ready receiver the next request can be taken in the cycle
//   after the response is loaded.
//   Reset (synchronous) restores the default capacities, marks all usage
//   entries as zero through the memory's valid bits and empties the output.
//   When the receiver stalls, a finished request waits in its final state until
//   the output register frees; usage is already updated at that point.
module tiered_memory_capacity_allocator (
   input  logic                       clock,
   input  logic                       reset,
   tmca_req_if.sink                   req_bus,
   tmca_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  tmca_pkg::tier_type         csr_index,
   input  tmca_pkg::size_type         csr_data
);
   import tmca_pkg::*;

   localparam int WIDE_W = SIZE_BITS + 4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_A_EVAL, ST_D_EVAL, ST_R_LOAD, ST_R_WAIT,
      ST_R_CMP, ST_R_MOVE, ST_R_LAST, ST_DONE
   } state_type;

   state_type  state_ff;
   size_type   cap_ff [NUM_TIERS];

   // Captured request
   kind_type   kind_ff;
   size_type   size_ff;
   addr_type   tix_ff;
   addr_type   pref_ff;
   addr_type   cand_ff;
   logic       up_ff;
   addr_type   pair_ff;

   // Reorganize working values
   size_type   lo_ff;
   size_type   hi_ff;
   size_type   room_ff;
   logic       high_ff;
   logic       low_ff;

   // Pending result and output register
   stat_type   res_status_ff;
   tier_type   res_tier_ff;
   size_type   res_used_ff;
   logic       rsp_valid_ff;
   stat_type   rsp_status_ff;
   tier_type   rsp_tier_ff;
   size_type   rsp_used_ff;

   // Memory and divider connections
   mem_wr_type mem_wr;
   addr_type   rd_addr;
   size_type   rd_data;
   logic       div_start;
   logic       div_busy;
   size_type   div_quot [NUM_TIERS];

   // Combinational helpers
   logic       req_fire;
   kind_type   req_kind;
   addr_type   pref_now;
   logic       tix_bad;
   logic       fit_now;
   logic [SIZE_BITS:0] alloc_sum;
   logic       more_cand;
   addr_type   next_cand;
   logic       next_up;
   size_type   free_val;
   addr_type   pair_lo;
   size_type   cap_lo;
   size_type   cap_hi;
   size_type   mv_high;
   size_type   mv_low;
   logic       high_ok;
   size_type   lo_in;
   size_type   hi_in;
   logic [WIDE_W-1:0] u_x10;
   logic [WIDE_W-1:0] c_x9;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_kind = kind_type'(req_bus.kind);
   assign pref_now = pref_tier(req_bus.priority_q8);
   assign tix_bad  = ({1'b0, req_bus.tier_index} >= (TIER_BITS + 1)'(NUM_TIERS));
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign div_start = req_fire && (req_kind == KIND_REORG);

   // Capacity registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TIERS; t++) begin
            cap_ff[t] <= CAP_RESET_TAB[t][SIZE_BITS-1:0];
         end
      end else if (csr_we) begin
         for (int t = 0; t < NUM_TIERS; t++) begin
            if (t < CAP_REGS && csr_index == TIER_BITS'(t)) begin
               cap_ff[t] <= csr_data;
            end
         end
      end
   end

   // Allocate scan: fit test and next candidate
   assign alloc_sum = {1'b0, rd_data} + {1'b0, size_ff};
   assign fit_now   = (alloc_sum <= {1'b0, cap_ff[cand_ff]});

   always_comb begin
      next_up = up_ff;
      if (up_ff && cand_ff != ADDR_BITS'(NUM_TIERS - 1)) begin
         more_cand = 1'b1;
         next_cand = cand_ff + 1'b1;
      end else if (up_ff) begin
         // upward pass done, continue below the preferred tier
         more_cand = (pref_ff != '0);
         next_cand = pref_ff - 1'b1;
         next_up   = 1'b0;
      end else begin
         more_cand = (cand_ff != '0);
         next_cand = cand_ff - 1'b1;
      end
   end

   // Deallocate with a floor at zero
   assign free_val = (size_ff > rd_data) ? '0 : rd_data - size_ff;

   // Reorganize pair (pair_lo, pair_ff)
   assign pair_lo = pair_ff - 1'b1;
   assign cap_lo  = cap_ff[pair_lo];
   assign cap_hi  = cap_ff[pair_ff];
   assign mv_high = div_quot[pair_lo];
   assign u_x10   = (WIDE_W'(lo_ff) << 3) + (WIDE_W'(lo_ff) << 1);
   assign c_x9    = (WIDE_W'(cap_lo) << 3) + WIDE_W'(cap_lo);
   assign high_ok = (({1'b0, hi_ff} + {1'b0, mv_high}) <= {1'b0, cap_hi})
                    && (mv_high <= lo_ff);
   assign mv_low  = (hi_ff < room_ff) ? hi_ff : room_ff;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (high_ff) begin
         if (high_ok) begin
            lo_in = lo_ff - mv_high;
            hi_in = hi_ff + mv_high;
         end
      end else if (low_ff) begin
         lo_in = lo_ff + mv_low;
         hi_in = hi_ff - mv_low;
      end
   end

   // Memory read address
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            unique case (req_kind)
               KIND_ALLOC:              rd_addr = pref_now;
               KIND_FREE, KIND_STATUS:  rd_addr = req_bus.tier_index[ADDR_BITS-1:0];
               KIND_REORG:              rd_addr = '0;
            endcase
         end
         ST_A_EVAL: rd_addr = next_cand;
         ST_R_WAIT: rd_addr = pair_ff;
         ST_R_MOVE: rd_addr = pair_ff + 1'b1;
         default:   rd_addr = cand_ff;
      endcase
   end

   // Memory write port
   always_comb begin
      mem_wr = '0;
      unique case (state_ff)
         ST_A_EVAL: begin
            mem_wr.en   = fit_now;
            mem_wr.addr = cand_ff;
            mem_wr.data = alloc_sum[SIZE_BITS-1:0];
         end
         ST_D_EVAL: begin
            mem_wr.en   = (kind_ff == KIND_FREE);
            mem_wr.addr = tix_ff;
            mem_wr.data = free_val;
         end
         ST_R_MOVE: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = pair_lo;
            mem_wr.data = lo_in;
         end
         ST_R_LAST: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = ADDR_BITS'(NUM_TIERS - 1);
            mem_wr.data = lo_ff;
         end
         default: mem_wr = '0;
      endcase
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drain the output register unless a new response loads it this cycle
         if (rsp_valid_ff && rsp_bus.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  kind_ff       <= req_kind;
                  size_ff       <= req_bus.req_size;
                  tix_ff        <= req_bus.tier_index[ADDR_BITS-1:0];
                  pref_ff       <= pref_now;
                  cand_ff       <= pref_now;
                  up_ff         <= 1'b1;
                  pair_ff       <= ADDR_BITS'(1);
                  res_status_ff <= ((req_kind == KIND_FREE || req_kind == KIND_STATUS)
                                    && tix_bad) ? STAT_BAD_TIER : STAT_OK;
                  res_tier_ff   <= '0;
                  res_used_ff   <= '0;
                  unique case (req_kind)
                     KIND_ALLOC: state_ff <= ST_A_EVAL;
                     KIND_FREE, KIND_STATUS: begin
                        if (tix_bad) begin
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_D_EVAL;
                        end
                     end
                     KIND_REORG: state_ff <= ST_R_LOAD;
                  endcase
               end
            end
            ST_A_EVAL: begin
               if (fit_now) begin
                  res_tier_ff <= TIER_BITS'(cand_ff);
                  res_used_ff <= alloc_sum[SIZE_BITS-1:0];
                  state_ff    <= ST_DONE;
               end else if (more_cand) begin
                  cand_ff <= next_cand;
                  up_ff   <= next_up;
               end else begin
                  res_status_ff <= STAT_NO_SPACE;
                  state_ff      <= ST_DONE;
               end
            end
            ST_D_EVAL: begin
               res_used_ff <= (kind_ff == KIND_FREE) ? free_val : rd_data;
               state_ff    <= ST_DONE;
            end
            ST_R_LOAD: begin
               lo_ff    <= rd_data;
               state_ff <= ST_R_WAIT;
            end
            ST_R_WAIT: begin
               if (!div_busy) begin
                  state_ff <= ST_R_CMP;
               end
            end
            ST_R_CMP: begin
               // pressure of the lower tier against its capacity
               hi_ff    <= rd_data;
               high_ff  <= (cap_lo != '0) && (u_x10 > c_x9);
               low_ff   <= (cap_lo == '0) || ({lo_ff, 1'b0} < {1'b0, cap_lo});
               room_ff  <= (lo_ff >= cap_lo) ? '0 : cap_lo - lo_ff;
               state_ff <= ST_R_MOVE;
            end
            ST_R_MOVE: begin
               lo_ff <= hi_in;
               if (pair_ff == ADDR_BITS'(NUM_TIERS - 1)) begin
                  state_ff <= ST_R_LAST;
               end else begin
                  pair_ff  <= pair_ff + 1'b1;
                  state_ff <= ST_R_CMP;
               end
            end
            ST_R_LAST: state_ff <= ST_DONE;
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_tier_ff   <= res_tier_ff;
                  rsp_used_ff   <= res_used_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.granted_tier = rsp_tier_ff;
   assign rsp_bus.tier_used    = rsp_used_ff;

   tmca_used_ram u_used_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tmca_div10 u_div10 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cap_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // Usage memory is never written while idle
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr.en)
      else $error("usage write while idle");

   // Pair processing only starts with the quotients settled
   a_div_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_CMP) |-> !div_busy)
      else $error("reorganize pair before divide finished");

   // An accepted request always leaves the idle state
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // A failed allocation reports no tier and no usage
   a_no_space_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_NO_SPACE)
         |-> (rsp_tier_ff == '0 && rsp_used_ff == '0))
      else $error("no-space response carries tier or usage");

endmodule

// ----- bench/tmca_usage_checker.sv -----
// Checker for the tiered memory capacity allocator: watches the request, response and
// capacity write ports, keeps its own tier usage model and compares every response.
// Depends on tmca_pkg, tmca_req_if and tmca_rsp_if.
module tmca_usage_checker (
   input  logic               clock,
   input  logic               reset,
   tmca_req_if                req_mon,
   tmca_rsp_if                rsp_mon,
   input  logic               csr_we,
   input  tmca_pkg::tier_type csr_index,
   input  tmca_pkg::size_type csr_data,
   output int                 errors,
   output int                 pending
);
   import tmca_pkg::*;

   typedef struct packed {
      stat_type status;
      tier_type granted_tier;
      size_type tier_used;
   } tier_reply_type;

   // Model copy of capacities and per-tier byte usage, 64 bits wide to keep sums exact
   logic [63:0]     tier_cap  [NUM_TIERS];
   logic [63:0]     tier_fill [NUM_TIERS];
   tier_reply_type  tier_replies_q [$];

   task automatic report_mismatch(input string msg);
      if (errors < 100) begin
         $display("MISMATCH %0t: %s", $time, msg);
      end
      errors++;
   endtask

   // Free bytes of a tier; none when the tier is at or over capacity
   function automatic logic [63:0] free_bytes(input int t);
      return (tier_fill[t] >= tier_cap[t]) ? 64'd0 : tier_cap[t] - tier_fill[t];
   endfunction

   function automatic bit takes_bytes(input int t, input logic [63:0] amount);
      return (tier_fill[t] <= tier_cap[t]) && (amount <= free_bytes(t));
   endfunction

   // Allocate: preferred tier upward, then slowest tier downward
   function automatic tier_reply_type charge_tier(input size_type amount,
                                                  input logic [8:0] prio);
      tier_reply_type res;
      logic [63:0]    prio_gap;
      int             start;
      int             hit;
      res.status       = STAT_OK;
      res.granted_tier = '0;
      res.tier_used    = '0;
      prio_gap = (prio >= 9'd256) ? 64'd0 : 64'd256 - 64'(prio);
      start    = int'((prio_gap * 64'(NUM_TIERS - 1)) >> 8);
      hit      = -1;
      for (int t = start; t < NUM_TIERS; t++) begin
         if (hit < 0 && takes_bytes(t, 64'(amount))) hit = t;
      end
      for (int t = NUM_TIERS - 1; t >= 0; t--) begin
         if (hit < 0 && takes_bytes(t, 64'(amount))) hit = t;
      end
      if (hit < 0) begin
         res.status = STAT_NO_SPACE;
      end else begin
         tier_fill[hit]  += 64'(amount);
         res.granted_tier = tier_type'(hit);
         res.tier_used    = size_type'(tier_fill[hit]);
      end
      return res;
   endfunction

   // Deallocate (floored at zero) or status read of one tier
   function automatic tier_reply_type release_or_read(input kind_type k,
                                                      input size_type amount,
                                                      input tier_type tix);
      tier_reply_type res;
      res.status       = STAT_OK;
      res.granted_tier = '0;
      res.tier_used    = '0;
      if (tix >= NUM_TIERS) begin
         res.status = STAT_BAD_TIER;
      end else begin
         if (k == KIND_FREE) begin
            tier_fill[tix] = (64'(amount) > tier_fill[tix]) ? 64'd0
                                                            : tier_fill[tix] - 64'(amount);
         end
         res.tier_used = size_type'(tier_fill[tix]);
      end
      return res;
   endfunction

   // Walk adjacent pairs: push a tenth of capacity down above 90%, pull back below 50%
   function automatic void rebalance_pairs();
      logic [63:0] u;
      logic [63:0] c;
      logic [63:0] amount;
      for (int t = 1; t < NUM_TIERS; t++) begin
         u = tier_fill[t-1];
         c = tier_cap[t-1];
         if (c != 0 && 10 * u > 9 * c) begin
            amount = c / 10;
            if (takes_bytes(t, amount) && amount <= u) begin
               tier_fill[t]   += amount;
               tier_fill[t-1] -= amount;
            end
         end else if ((c == 0 || 2 * u < c) && tier_fill[t] != 0) begin
            amount = (tier_fill[t] < free_bytes(t-1)) ? tier_fill[t] : free_bytes(t-1);
            tier_fill[t-1] += amount;
            tier_fill[t]   -= amount;
         end
      end
   endfunction

   function automatic tier_reply_type serve_request(input logic [1:0] kind_bits,
                                                    input size_type amount,
                                                    input logic [8:0] prio,
                                                    input tier_type tix);
      tier_reply_type res;
      res.status       = STAT_OK;
      res.granted_tier = '0;
      res.tier_used    = '0;
      case (kind_type'(kind_bits))
         KIND_ALLOC: begin
            res = charge_tier(amount, prio);
         end
         KIND_FREE, KIND_STATUS: begin
            res = release_or_read(kind_type'(kind_bits), amount, tix);
         end
         default: begin
            rebalance_pairs();
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      tier_reply_type want;
      if (reset) begin
         for (int t = 0; t < NUM_TIERS; t++) begin
            tier_cap[t]  = 64'(size_type'(CAP_RESET_TAB[t]));
            tier_fill[t] = 64'd0;
         end
         tier_replies_q.delete();
         pending <= 0;
      end else begin
         // capacity writes; indexes past the last tier are dropped
         if (csr_we && csr_index < CAP_REGS && csr_index < NUM_TIERS) begin
            tier_cap[csr_index] = 64'(csr_data);
         end
         if (req_mon.valid && req_mon.ready) begin
            tier_replies_q.insert(tier_replies_q.size(),
                                  serve_request(req_mon.kind, req_mon.req_size,
                                                req_mon.priority_q8, req_mon.tier_index));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tier_replies_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = tier_replies_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_mon.status, want.status));
               end
               if (rsp_mon.granted_tier !== want.granted_tier) begin
                  report_mismatch($sformatf("granted_tier %0d, expected %0d",
                                            rsp_mon.granted_tier, want.granted_tier));
               end
               if (rsp_mon.tier_used !== want.tier_used) begin
                  report_mismatch($sformatf("tier_used %0d, expected %0d",
                                            rsp_mon.tier_used, want.tier_used));
               end
            end
         end
         pending <= tier_replies_q.size();
      end
   end

endmodule

// ----- bench/tb_tiered_memory_capacity_allocator.sv -----
// Testbench top of the tiered memory capacity allocator: clock, reset, capacity
// programming, request stimulus and response back-pressure; gives the verdict.
// Depends on tmca_pkg, both channel interfaces, the block and tmca_usage_checker.
module tb_tiered_memory_capacity_allocator;
   import tmca_pkg::*;

   localparam int          PHASES      = 9;
   localparam int          PHASE_ITEMS = 60;
   localparam int          LONG_HOLD   = 300;
   localparam int          DRAIN_WAIT  = 40;
   localparam longint      WATCHDOG    = 64'd6_000_000;
   localparam logic [63:0] SIZE_MAX    = (64'd1 << SIZE_BITS) - 1;
   localparam size_type    SIZE_ALL    = '1;
   localparam size_type    MIB         = size_type'(64'd1 << 20);

   logic        clock;
   logic        reset;
   logic        csr_we;
   tier_type    csr_index;
   size_type    csr_data;
   int          errors;
   int          pending;
   bit          burst_mode;
   bit          long_hold_req;
   logic [63:0] cap_now [NUM_TIERS];

   tmca_req_if req_bus ();
   tmca_rsp_if rsp_bus ();

   tiered_memory_capacity_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tmca_usage_checker usage_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_bus),
      .rsp_mon   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Idle lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sizes scaled to a tier capacity so that tiers fill and drain
   function automatic size_type pick_size(input logic [63:0] scale);
      int          r;
      logic [63:0] raw;
      r   = $urandom_range(0, 99);
      raw = {$urandom, $urandom};
      if (r < 4) return '0;
      if (r < 8) return SIZE_ALL;
      if (r < 16) return size_type'(raw);
      if (scale == 0) return size_type'(raw % 16);
      return size_type'(raw % (scale / 3 + 1));
   endfunction

   task automatic send_request(input kind_type k, input size_type sz,
                               input logic [8:0] prio, input tier_type tix);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= k;
      req_bus.req_size    <= sz;
      req_bus.priority_q8 <= prio;
      req_bus.tier_index  <= tix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid    <= 1'b0;
         req_bus.req_size <= size_type'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_replies();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Write all capacities, then one index past the last tier that must be dropped
   task automatic program_caps();
      for (int i = 0; i < NUM_TIERS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= tier_type'(i);
         csr_data  <= size_type'(cap_now[i]);
         @(posedge clock);
      end
      csr_index <= tier_type'($urandom_range(CAP_REGS, 7));
      csr_data  <= size_type'({$urandom, $urandom});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic choose_caps(input int ph);
      for (int i = 0; i < NUM_TIERS; i++) begin
         case (ph)
            0, 3: begin
               cap_now[i] = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(50, 2000));
            end
            1: begin
               cap_now[i] = (i % 2 == 0) ? SIZE_MAX : 64'd0;
            end
            2: begin
               cap_now[i] = SIZE_MAX;
            end
            4: begin
               cap_now[i] = 64'd0;
            end
            default: begin
               cap_now[i] = {$urandom, $urandom} % (64'd1 << $urandom_range(4, SIZE_BITS));
            end
         endcase
      end
   endtask

   task automatic send_random_request();
      int          r;
      kind_type    k;
      logic [8:0]  prio;
      tier_type    tix;
      r = $urandom_range(0, 99);
      if (r < 45) k = KIND_ALLOC;
      else if (r < 70) k = KIND_FREE;
      else if (r < 85) k = KIND_STATUS;
      else k = KIND_REORG;
      prio = ($urandom_range(0, 99) < 88) ? 9'($urandom_range(0, 256))
                                          : 9'($urandom_range(257, 511));
      tix  = ($urandom_range(0, 99) < 90) ? tier_type'($urandom_range(0, NUM_TIERS - 1))
                                          : tier_type'($urandom_range(NUM_TIERS, 7));
      send_request(k, pick_size(cap_now[$urandom_range(0, NUM_TIERS - 1)]), prio, tix);
   endtask

   // Directed requests at the reset capacities
   task automatic run_directed();
      send_request(KIND_STATUS, '0, 9'd0, 3'd0);
      send_request(KIND_STATUS, '0, 9'd0, 3'd5);
      send_request(KIND_STATUS, SIZE_ALL, 9'd511, 3'd7);
      send_request(KIND_ALLOC, '0, 9'd256, 3'd0);
      // push tier 0 past 90%, then overflow into tier 1 with a saturated priority
      send_request(KIND_ALLOC, 62 * MIB, 9'd256, 3'd0);
      send_request(KIND_ALLOC, 4 * MIB, 9'd511, 3'd0);
      send_request(KIND_ALLOC, SIZE_ALL, 9'd0, 3'd0);
      send_request(KIND_ALLOC, 64 * MIB, 9'd0, 3'd7);
      send_request(KIND_ALLOC, size_type'(1), 9'd128, 3'd0);
      send_request(KIND_ALLOC, size_type'(1), 9'd1, 3'd0);
      send_request(KIND_ALLOC, size_type'(1), 9'd255, 3'd0);
      send_request(KIND_REORG, '0, 9'd0, 3'd0);
      send_request(KIND_STATUS, '0, 9'd0, 3'd0);
      send_request(KIND_STATUS, '0, 9'd0, 3'd1);
      // release more than held, then let reorganize pull bytes back up
      send_request(KIND_FREE, SIZE_ALL, 9'd0, 3'd0);
      send_request(KIND_REORG, SIZE_ALL, 9'd511, 3'd7);
      send_request(KIND_STATUS, '0, 9'd0, 3'd0);
      send_request(KIND_FREE, size_type'(5), 9'd0, 3'd6);
      send_request(KIND_FREE, size_type'(1), 9'd0, 3'd2);
      send_request(KIND_STATUS, '0, 9'd0, 3'd4);
      send_request(KIND_ALLOC, 16 * 1024 * MIB, 9'd0, 3'd0);
      send_request(KIND_FREE, '0, 9'd0, 3'd4);
   endtask

   // Response side: random stalls, runs without stalls, one long hold on request
   initial begin : reply_side
      int stall;
      int run;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (int n = 0; n < LONG_HOLD; n++) @(posedge clock);
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_ALLOC;
      req_bus.req_size    <= '0;
      req_bus.priority_q8 <= '0;
      req_bus.tier_index  <= '0;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_data            <= '0;
      burst_mode    = 1'b0;
      long_hold_req = 1'b0;
      for (int i = 0; i < NUM_TIERS; i++) cap_now[i] = 64'(size_type'(CAP_RESET_TAB[i]));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_for_replies();

      for (int ph = 0; ph < PHASES; ph++) begin
         choose_caps(ph);
         program_caps();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            // fill the block against a held-off receiver, later drain fully mid-phase
            if (ph == 0 && n == 20) long_hold_req = 1'b1;
            if (ph == 0 && n == 40) wait_for_replies();
            send_random_request();
         end
         wait_for_replies();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tiered_memory_capacity_allocator verification clean");
      end else begin
         $display("tiered_memory_capacity_allocator verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #WATCHDOG;
      $display("tiered_memory_capacity_allocator verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/tmca_pkg.sv
rtl/core/tmca_req_if.sv
rtl/core/tmca_rsp_if.sv
rtl/core/tmca_used_ram.sv
rtl/core/tmca_div10.sv
rtl/core/tiered_memory_capacity_allocator.sv
bench/tmca_usage_checker.sv
bench/tb_tiered_memory_capacity_allocator.sv
